### design/lsd_pkg.sv
// Shared types, constants and helpers for the lift and set-down detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lsd_pkg;

  // Tick limits of the phase timers
  localparam int STILL_TICKS        = 10;
  localparam int LIFT_WAIT_TICKS    = 400;
  localparam int SPIN_WAIT_TICKS    = 200;
  localparam int SETDOWN_WAIT_TICKS = 50;

  localparam int STILL_CNT_W = 4;
  localparam int LIFT_CNT_W  = 9;
  localparam int SPIN_CNT_W  = 8;
  localparam int DOWN_CNT_W  = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STILL_SPEED = 3'd0,
    CFG_LIFT_ACCEL  = 3'd1,
    CFG_LEVEL_ANGLE = 3'd2,
    CFG_SPIN_SPEED  = 3'd3,
    CFG_REST_SPEED  = 3'd4,
    CFG_TURN_SPEED  = 3'd5
  } lsd_cfg_idx_t;

  typedef struct packed {
    logic        [16:0] still_speed_limit;
    logic signed [15:0] lift_accel_threshold;
    logic        [15:0] level_angle_limit;
    logic        [16:0] spin_speed_limit;
    logic        [15:0] rest_speed_limit;
    logic        [15:0] turned_speed_limit;
  } lsd_cfg_t;

  // One sensor tick; accel_z sits in the lowest bits
  typedef struct packed {
    logic signed [15:0] right_speed;
    logic signed [15:0] left_speed;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] accel_z;
  } lsd_item_t;

  // Threshold tests of one tick
  typedef struct packed {
    logic still;   // |l|+|r| below still limit
    logic jolt;    // accel above threshold and body level
    logic spin;    // |l+r| above spin limit
    logic rest;    // body level and both wheels resting
    logic turned;  // both wheels turned by hand
  } lsd_flags_t;

  typedef enum logic [2:0] {
    LP_STILL = 3'b001,
    LP_JOLT  = 3'b010,
    LP_SPIN  = 3'b100
  } lsd_lift_phase_t;

  typedef enum logic [1:0] {
    DP_REST = 2'b01,
    DP_TURN = 2'b10
  } lsd_down_phase_t;

  // Magnitude of a 17-bit signed value, exact for the most negative code
  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    logic signed [17:0] x;
    logic signed [17:0] n;
    begin
      x = {v[16], v};
      n = -x;
      return x[17] ? n[16:0] : x[16:0];
    end
  endfunction

  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    return mag17({v[15], v});
  endfunction

endpackage

### design/lsd_flags.sv
// Threshold tests: magnitudes and compares of one registered tick.
// Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_flags
  import lsd_pkg::*;
(
  input  lsd_item_t  item,
  input  lsd_cfg_t   cfg,
  output lsd_flags_t flags
);

  logic [16:0] mag_l;
  logic [16:0] mag_r;
  logic [16:0] mag_pitch;
  logic [17:0] mag_sum;
  logic [16:0] mag_net;
  logic        level;

  assign mag_l     = mag16(item.left_speed);
  assign mag_r     = mag16(item.right_speed);
  assign mag_pitch = mag16(item.pitch_angle);
  assign mag_sum   = {1'b0, mag_l} + {1'b0, mag_r};
  assign mag_net   = mag17(17'(item.left_speed) + 17'(item.right_speed));
  assign level     = mag_pitch < {1'b0, cfg.level_angle_limit};

  always_comb begin
    flags.still  = mag_sum < {1'b0, cfg.still_speed_limit};
    flags.jolt   = (item.accel_z > cfg.lift_accel_threshold) && level;
    flags.spin   = mag_net > cfg.spin_speed_limit;
    flags.rest   = level && (mag_l < {1'b0, cfg.rest_speed_limit})
                         && (mag_r < {1'b0, cfg.rest_speed_limit});
    flags.turned = (mag_l > {1'b0, cfg.turned_speed_limit})
                && (mag_r > {1'b0, cfg.turned_speed_limit});
  end

endmodule

### design/lsd_lift.sv
// Three-phase lift detector: still wheels, level jolt, wheel runaway.
// Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_lift
  import lsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  lsd_flags_t flags,
  output logic       lifted
);

  lsd_lift_phase_t       phase;
  lsd_lift_phase_t       phase_next;
  logic [STILL_CNT_W-1:0] still_count;
  logic [STILL_CNT_W-1:0] still_count_next;
  logic [LIFT_CNT_W-1:0]  lift_wait_count;
  logic [LIFT_CNT_W-1:0]  lift_wait_count_next;
  logic [SPIN_CNT_W-1:0]  spin_wait_count;
  logic [SPIN_CNT_W-1:0]  spin_wait_count_next;

  // A phase entered on this tick is evaluated on this tick too
  always_comb begin
    phase_next           = phase;
    still_count_next     = still_count;
    lift_wait_count_next = lift_wait_count;
    spin_wait_count_next = spin_wait_count;
    lifted               = 1'b0;

    if (phase_next == LP_STILL) begin
      still_count_next = flags.still ? still_count + 1'b1 : '0;
      if (still_count_next > STILL_CNT_W'(STILL_TICKS)) begin
        phase_next       = LP_JOLT;
        still_count_next = '0;
      end
    end

    if (phase_next == LP_JOLT) begin
      lift_wait_count_next = lift_wait_count + 1'b1;
      if (lift_wait_count_next > LIFT_CNT_W'(LIFT_WAIT_TICKS)) begin
        lift_wait_count_next = '0;
        phase_next           = LP_STILL;
      end
      // jolt wins over the timeout
      if (flags.jolt) begin
        phase_next = LP_SPIN;
      end
    end

    if (phase_next == LP_SPIN) begin
      spin_wait_count_next = spin_wait_count + 1'b1;
      if (spin_wait_count_next > SPIN_CNT_W'(SPIN_WAIT_TICKS)) begin
        spin_wait_count_next = '0;
        phase_next           = LP_STILL;
      end
      if (flags.spin) begin
        phase_next = LP_STILL;
        lifted     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= LP_STILL;
      still_count     <= '0;
      lift_wait_count <= '0;
      spin_wait_count <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      still_count     <= still_count_next;
      lift_wait_count <= lift_wait_count_next;
      spin_wait_count <= spin_wait_count_next;
    end
  end

endmodule

### design/lsd_down.sv
// Two-phase set-down detector: level and resting, then wheels turned by hand.
// Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_down
  import lsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       stopped,  // stop flag as the lift detector leaves it
  input  lsd_flags_t flags,
  output logic       down
);

  lsd_down_phase_t       phase;
  lsd_down_phase_t       phase_next;
  logic [DOWN_CNT_W-1:0] down_wait_count;
  logic [DOWN_CNT_W-1:0] down_wait_count_next;
  logic                  found;

  always_comb begin
    phase_next           = phase;
    down_wait_count_next = down_wait_count;
    found                = 1'b0;

    if (phase_next == DP_REST && flags.rest) begin
      phase_next = DP_TURN;
    end

    if (phase_next == DP_TURN) begin
      down_wait_count_next = down_wait_count + 1'b1;
      if (down_wait_count_next > DOWN_CNT_W'(SETDOWN_WAIT_TICKS)) begin
        down_wait_count_next = '0;
        phase_next           = DP_REST;
      end
      if (flags.turned) begin
        phase_next = DP_REST;
        found      = 1'b1;
      end
    end
  end

  // Forced low while not stopped; the phase state is frozen then too
  assign down = stopped && found;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= DP_REST;
      down_wait_count <= '0;
    end else if (advance && stopped) begin
      phase           <= phase_next;
      down_wait_count <= down_wait_count_next;
    end
  end

endmodule

### design/lift_and_set_down_detector.sv
// Top level of the lift and set-down detector; configuration registers,
// input and result registers. Depends on lsd_pkg, lsd_flags, lsd_lift, lsd_down.
`timescale 1ns / 1ps

// Pickup / put-down detection for a two-wheeled balancing robot. Each
// transfer on the s_ side is one control tick (accel_z, pitch_angle,
// left_speed, right_speed) and yields exactly one transfer on the m_ side
// carrying stop_active, picked_up and set_down. A lift is seen after the
// wheels have been still for more than 10 ticks, then an upward jolt while
// level (within 400 ticks), then wheel runaway (within 200 ticks); it sets
// the stop flag. While stopped, a level body with resting wheels followed by
// both wheels turned by hand (within 50 ticks) clears it. The tick is held in
// the input register, then all tests and phase updates run in a single pass
// into the result register, from which the result transfer is offered. One
// tick is taken every cycle as long as the result side keeps up; a stalled
// result holds only the result register, and the input register still takes
// one more tick. Thresholds are written through the cfg_ port, always ready;
// the user must write them only while no tick is in flight, which the block
// itself does not enforce.
module lift_and_set_down_detector
  import lsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tick input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // accel_z, pitch_angle, left_speed, right_speed
  // result output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // stop_active, picked_up, set_down, 5'b0
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lsd_cfg_t   cfg;
  lsd_item_t  item;
  logic       item_valid;
  logic       advance;
  lsd_flags_t flags;
  logic       lifted;
  logic       down;
  logic       stop_flag;
  logic       stop_lifted;
  logic       stop_next;

  // --- configuration registers ---
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.still_speed_limit    <= 17'd100;
      cfg.lift_accel_threshold <= 16'sd192;
      cfg.level_angle_limit    <= 16'd1000;
      cfg.spin_speed_limit     <= 17'd15000;
      cfg.rest_speed_limit     <= 16'd20;
      cfg.turned_speed_limit   <= 16'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STILL_SPEED: cfg.still_speed_limit    <= cfg_data;
        CFG_LIFT_ACCEL:  cfg.lift_accel_threshold <= cfg_data[15:0];
        CFG_LEVEL_ANGLE: cfg.level_angle_limit    <= cfg_data[15:0];
        CFG_SPIN_SPEED:  cfg.spin_speed_limit     <= cfg_data;
        CFG_REST_SPEED:  cfg.rest_speed_limit     <= cfg_data[15:0];
        CFG_TURN_SPEED:  cfg.turned_speed_limit   <= cfg_data[15:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // --- input register ---
  // The tick moves on whenever the result register is free or being drained.
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= lsd_item_t'(s_tdata);
    end
  end

  // --- single-pass evaluation ---
  lsd_flags u_flags (
    .item  (item),
    .cfg   (cfg),
    .flags (flags)
  );

  lsd_lift u_lift (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .flags   (flags),
    .lifted  (lifted)
  );

  // Set-down sees the flag as the lift detector left it on the same tick
  assign stop_lifted = stop_flag || lifted;

  lsd_down u_down (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .stopped (stop_lifted),
    .flags   (flags),
    .down    (down)
  );

  assign stop_next = stop_lifted && !down;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_flag <= 1'b0;
    end else if (advance) begin
      stop_flag <= stop_next;
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, down, lifted, stop_next};
    end
  end

endmodule

### sim/lift_and_set_down_detector_tb.sv
// Self-checking testbench for lift_and_set_down_detector: directed ticks, then
// scripted pickup / put-down sequences under several threshold settings.
// Depends on lsd_pkg and the design sources; needs no files or arguments.
`timescale 1ns / 1ps

module lift_and_set_down_detector_tb;
  import lsd_pkg::*;

  localparam int IDLE_LIMIT  = 2000; // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 80;   // long receiver hold-off, fills the block
  localparam int SETTLE_CYC  = 4;    // margin for the block to empty after the last result

  // Phase codes of the two detectors
  localparam logic [1:0] PH_STILL = 2'd0;
  localparam logic [1:0] PH_JOLT  = 2'd1;
  localparam logic [1:0] PH_SPIN  = 2'd2;
  localparam logic       DN_REST  = 1'b0;
  localparam logic       DN_TURN  = 1'b1;

  // Result transfer, laid out as m_tdata from bit 0 up
  typedef struct packed {
    logic [4:0] pad;
    logic       set_down;
    logic       picked_up;
    logic       stop_active;
  } tick_flags_t;

  localparam tick_flags_t FLAGS_NONE = '0;

  typedef struct packed {
    lsd_item_t tick;
    logic      typed;  // expect FLAGS_NONE, read off by hand
  } dir_row_t;

  typedef enum int {TK_NOISE, TK_STILL, TK_JOLT, TK_SPIN, TK_REST, TK_TURN, TK_QUIET}
    tick_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata = '0;   // accel_z, pitch_angle, left_speed, right_speed
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // stop_active, picked_up, set_down, 5'b0
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lift_and_set_down_detector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Detector model: thresholds and phase state, advanced once per accepted tick
  // ---------------------------------------------------------------------------
  logic        [16:0] lim_still = 17'd100;
  logic signed [15:0] accel_thr = 16'sd192;
  logic        [15:0] lim_level = 16'd1000;
  logic        [16:0] lim_spin  = 17'd15000;
  logic        [15:0] lim_rest  = 16'd20;
  logic        [15:0] lim_turn  = 16'd50;

  logic [1:0]            lift_ph   = PH_STILL;
  logic [STILL_CNT_W-1:0] still_cnt = '0;
  logic [LIFT_CNT_W-1:0]  lift_wait = '0;
  logic [SPIN_CNT_W-1:0]  spin_wait = '0;
  logic                  down_ph   = DN_REST;
  logic [DOWN_CNT_W-1:0]  down_wait = '0;
  logic                  halted    = 1'b0;

  tick_flags_t tick_flags_q[$];  // predicted flags, oldest first

  int errors = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int lifts = 0;
  int set_downs = 0;
  int settings = 0;
  int holds = 0;
  bit tx_calm = 1'b0;     // sender offers back to back
  bit rx_holding = 1'b0;  // receiver in its long hold-off

  // All magnitudes in int, so |-32768| and |l+r| come out exact.
  function automatic tick_flags_t detector_advance(lsd_item_t it);
    int acc, pitch, l, r, ml, mr, mp, mlr;
    logic up, down;
    tick_flags_t res;
    acc   = $signed(it.accel_z);
    pitch = $signed(it.pitch_angle);
    l     = $signed(it.left_speed);
    r     = $signed(it.right_speed);
    ml  = (l < 0) ? -l : l;
    mr  = (r < 0) ? -r : r;
    mp  = (pitch < 0) ? -pitch : pitch;
    mlr = (l + r < 0) ? -(l + r) : l + r;
    up = 1'b0;
    down = 1'b0;

    // Lift: phases fall through on the tick they are entered
    if (lift_ph == PH_STILL) begin
      if (ml + mr < int'(lim_still)) still_cnt = still_cnt + 1'b1;
      else still_cnt = '0;
      if (still_cnt > STILL_TICKS) begin
        lift_ph = PH_JOLT;
        still_cnt = '0;
      end
    end
    if (lift_ph == PH_JOLT) begin
      lift_wait = lift_wait + 1'b1;
      if (lift_wait > LIFT_WAIT_TICKS) begin
        lift_wait = '0;
        lift_ph = PH_STILL;
      end
      // a jolt on the timeout tick still wins
      if (acc > int'(accel_thr) && mp < int'(lim_level)) lift_ph = PH_SPIN;
    end
    if (lift_ph == PH_SPIN) begin
      spin_wait = spin_wait + 1'b1;
      if (spin_wait > SPIN_WAIT_TICKS) begin
        spin_wait = '0;
        lift_ph = PH_STILL;
      end
      if (mlr > int'(lim_spin)) begin
        lift_ph = PH_STILL;
        up = 1'b1;
      end
    end
    if (up) halted = 1'b1;

    // Set-down only moves while halted; sees the flag as the lift left it
    if (halted) begin
      if (down_ph == DN_REST && mp < int'(lim_level) && ml < int'(lim_rest) &&
          mr < int'(lim_rest))
        down_ph = DN_TURN;
      if (down_ph == DN_TURN) begin
        down_wait = down_wait + 1'b1;
        if (down_wait > SETDOWN_WAIT_TICKS) begin
          down_wait = '0;
          down_ph = DN_REST;
        end
        if (ml > int'(lim_turn) && mr > int'(lim_turn)) begin
          down_ph = DN_REST;
          down = 1'b1;
        end
      end
    end
    if (down) halted = 1'b0;

    res = FLAGS_NONE;
    res.stop_active = halted;
    res.picked_up = up;
    res.set_down = down;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random value helpers
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // magnitude in [0, hi], hitting hi itself a quarter of the time
  function automatic int rmag(int hi);
    if (hi <= 0) return 0;
    if (hi > 32768) hi = 32768;
    if ($urandom_range(0, 3) == 0) return hi;
    return $urandom_range(0, hi);
  endfunction

  function automatic int sgn(int m);
    if (m >= 32768) return -32768;
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // One tick shaped to meet a given test under the current thresholds; where a
  // setting makes the test unreachable the nearest value is used instead.
  function automatic lsd_item_t make_tick(tick_kind_t k);
    lsd_item_t t;
    int thr, tot, m;
    t = {$urandom, $urandom};
    thr = accel_thr;
    case (k)
      TK_STILL: begin
        t.left_speed  = 16'(sgn(rmag((int'(lim_still) - 1) / 2)));
        t.right_speed = 16'(sgn(rmag((int'(lim_still) - 1) / 2)));
      end
      TK_JOLT, TK_QUIET: begin
        if (k == TK_QUIET) t.accel_z = 16'(thr - rmag(thr + 32768));
        else if (thr >= 32767) t.accel_z = 16'sh7fff;
        else t.accel_z = 16'(thr + 1 + rmag(32766 - thr));
        t.pitch_angle = 16'(sgn(rmag(int'(lim_level) - 1)));
        if (k == TK_QUIET || $urandom_range(0, 1)) begin
          t.left_speed  = 16'(sgn(rmag((int'(lim_still) - 1) / 2)));
          t.right_speed = 16'(sgn(rmag((int'(lim_still) - 1) / 2)));
        end
      end
      TK_SPIN: begin
        tot = (lim_spin >= 17'd65536) ? 65536 : int'(lim_spin) + 1 + rmag(65535 - lim_spin);
        if ($urandom_range(0, 1) && tot <= 65534) begin
          t.left_speed  = 16'(tot / 2);
          t.right_speed = 16'(tot - tot / 2);
        end else begin
          t.left_speed  = 16'(-(tot / 2));
          t.right_speed = 16'(-(tot - tot / 2));
        end
      end
      TK_REST: begin
        t.pitch_angle = 16'(sgn(rmag(int'(lim_level) - 1)));
        t.left_speed  = 16'(sgn(rmag(int'(lim_rest) - 1)));
        t.right_speed = 16'(sgn(rmag(int'(lim_rest) - 1)));
      end
      TK_TURN: begin
        if (lim_turn >= 16'd32768) begin
          t.left_speed  = 16'sh8000;
          t.right_speed = 16'sh8000;
        end else begin
          m = int'(lim_turn) + 1;
          t.left_speed  = 16'(sgn(m + rmag(32767 - m)));
          t.right_speed = 16'(sgn(m + rmag(32767 - m)));
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic tick_kind_t filler_kind();
    case ($urandom_range(0, 2))
      0: return TK_STILL;
      1: return TK_REST;
      default: return TK_NOISE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers; all called right after a falling edge
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // One tick transfer; the prediction is taken at the accepting edge.
  // typed rows queue the hand-written flags, the model still advances.
  task automatic send_tick(lsd_item_t it, logic typed = 1'b0);
    int gap;
    tick_flags_t want;
    gap = (tx_calm || rx_holding) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = it;
    do @(posedge clk); while (!s_tready);
    want = detector_advance(it);
    lifts += want.picked_up;
    set_downs += want.set_down;
    tick_flags_q.push_back(typed ? FLAGS_NONE : want);
    ticks_sent++;
    if (ticks_sent % 50 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(lsd_cfg_idx_t idx, int val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val[16:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STILL_SPEED: lim_still = cfg_data[16:0];
      CFG_LIFT_ACCEL:  accel_thr = cfg_data[15:0];
      CFG_LEVEL_ANGLE: lim_level = cfg_data[15:0];
      CFG_SPIN_SPEED:  lim_spin  = cfg_data[16:0];
      CFG_REST_SPEED:  lim_rest  = cfg_data[15:0];
      CFG_TURN_SPEED:  lim_turn  = cfg_data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Quiet the input, drain every pending result, then let the pipeline empty.
  task automatic settle();
    s_tvalid = 1'b0;
    while (tick_flags_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Thresholds change only with the block idle
  task automatic apply_config(int still, int acc, int level, int spin, int rest, int turn);
    settle();
    write_reg(CFG_STILL_SPEED, still);
    write_reg(CFG_LIFT_ACCEL, acc);
    write_reg(CFG_LEVEL_ANGLE, level);
    write_reg(CFG_SPIN_SPEED, spin);
    write_reg(CFG_REST_SPEED, rest);
    write_reg(CFG_TURN_SPEED, turn);
    settings++;
  endtask

  // Mostly well-formed pickup and put-down sequences with random content, the
  // rest broken sequences and noise. Rare long waits push the phase timers
  // (which only clear on their own timeout) past their limits.
  task automatic run_sequences(int n);
    int stop_at, r;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        repeat ($urandom_range(11, 14)) send_tick(make_tick(TK_STILL));
        if ($urandom_range(0, 19) == 0)
          repeat ($urandom_range(30, 150)) send_tick(make_tick(TK_QUIET));
        repeat ($urandom_range(0, 3)) send_tick(make_tick(filler_kind()));
        send_tick(make_tick(TK_JOLT));
        if ($urandom_range(0, 14) == 0)
          repeat ($urandom_range(30, 120)) send_tick(make_tick(TK_QUIET));
        repeat ($urandom_range(0, 3)) send_tick(make_tick(filler_kind()));
        send_tick(make_tick(TK_SPIN));
      end else if (r < 75) begin
        send_tick(make_tick(TK_REST));
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(20, 60)) send_tick(make_tick(TK_REST));
        else
          repeat ($urandom_range(0, 3)) send_tick(make_tick(filler_kind()));
        send_tick(make_tick(TK_TURN));
      end else if (r < 88) begin
        // too short a still run, then the rest of a lift
        repeat ($urandom_range(3, 9)) send_tick(make_tick(TK_STILL));
        send_tick(make_tick(TK_JOLT));
        send_tick(make_tick(TK_SPIN));
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(make_tick(TK_NOISE));
      end
    end
  endtask

  task automatic add_row(ref dir_row_t rows[$], input int acc, input int pitch,
                         input int l, input int r, input logic typed);
    dir_row_t row;
    row.tick.accel_z     = 16'(acc);
    row.tick.pitch_angle = 16'(pitch);
    row.tick.left_speed  = 16'(l);
    row.tick.right_speed = 16'(r);
    row.typed = typed;
    rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, long hold-offs every 400 results, in-order compare
  // ---------------------------------------------------------------------------
  initial begin
    int stall, hold_left, next_hold, cyc;
    bit rx_calm;
    tick_flags_t got, want;
    stall = 0;
    hold_left = 0;
    next_hold = 250;
    cyc = 0;
    rx_calm = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && results_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += 400;
        holds++;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else if (rx_calm) begin
        m_tready = 1'b1;
      end else begin
        stall = pick_gap();
        m_tready = (stall == 0);
        if (stall > 0) stall--;
      end
      rx_holding = (hold_left > 0);
      cyc++;
      if (cyc % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);

      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (tick_flags_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no tick pending, data %02h",
                                    results_seen, m_tdata));
        end else begin
          want = tick_flags_q.pop_front();
          if (got.stop_active !== want.stop_active)
            report_mismatch($sformatf("result %0d stop_active %b, want %b",
                                      results_seen, got.stop_active, want.stop_active));
          if (got.picked_up !== want.picked_up)
            report_mismatch($sformatf("result %0d picked_up %b, want %b",
                                      results_seen, got.picked_up, want.picked_up));
          if (got.set_down !== want.set_down)
            report_mismatch($sformatf("result %0d set_down %b, want %b",
                                      results_seen, got.set_down, want.set_down));
          if (got.pad !== want.pad)
            report_mismatch($sformatf("result %0d pad bits %b, want zero",
                                      results_seen, got.pad));
        end
      end
    end
  end

  // Watchdog: any transfer on any port restarts the count
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results pending",
             IDLE_LIMIT, tick_flags_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t rows[$];

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed ticks under the reset thresholds. Nothing can be lifted before
    // eleven still ticks, so the first twelve rows must give all-zero flags.
    add_row(rows, -32768, -32768, -32768, -32768, 1'b1); // field minimum
    add_row(rows,  32767,  32767,  32767,  32767, 1'b1); // field maximum
    add_row(rows,  32767, -32768,      0,      0, 1'b1); // still run starts
    add_row(rows, -32768,  32767,      0,      0, 1'b1);
    add_row(rows,      0,      0,     49,    -50, 1'b1); // sum 99, just still
    add_row(rows,    192,    999,    -49,     50, 1'b1);
    add_row(rows,    193,  -1000,      1,     -1, 1'b1);
    add_row(rows,      0,      0,      0,      0, 1'b1);
    add_row(rows,  -1234,   4321,     10,     10, 1'b1);
    add_row(rows,      1,     -1,    -30,     30, 1'b1);
    add_row(rows,   5000,    500,     20,     -5, 1'b1);
    add_row(rows,      7,     -7,      0,     -2, 1'b1);
    // eleventh still tick is also a jolt: both phase steps on one tick
    add_row(rows,  32767,      0,      0,      0, 1'b0);
    add_row(rows,      0,      0, -32768, -32768, 1'b0); // runaway: lifted
    // halted: level and resting, which also counts as still
    add_row(rows,      0,    999,     19,    -19, 1'b0);
    add_row(rows,      0,   -999,    -19,     19, 1'b0);
    add_row(rows,    100,      0,      0,      0, 1'b0);
    add_row(rows,   -100,      0,      0,      0, 1'b0);
    add_row(rows,      0,     10,      5,      5, 1'b0);
    add_row(rows,      0,    -10,     -5,     -5, 1'b0);
    add_row(rows,      0,      0,      0,      0, 1'b0);
    add_row(rows,      0,      0,      0,      0, 1'b0);
    add_row(rows,      0,      0,      0,      0, 1'b0);
    add_row(rows,      0,      0,      0,      0, 1'b0);
    add_row(rows,    193,   -999,      0,      0, 1'b0); // jolt on the eleventh
    // lift and set-down on one tick: both flags, stop ends low
    add_row(rows,      0,      0,  32767,  32767, 1'b0);
    foreach (rows[i]) send_tick(rows[i].tick, rows[i].typed);

    // Reset thresholds written explicitly
    apply_config(100, 192, 1000, 15000, 20, 50);
    run_sequences(300);

    // Every limit at its low end: nothing counts as still or level
    apply_config(0, -32768, 0, 0, 0, 0);
    run_sequences(60);

    // Every limit at its high end: wheels can never run away
    apply_config(65536, 32767, 32768, 65536, 32768, 32768);
    run_sequences(60);

    // Mixed extremes that make both detectors fire easily
    apply_config(65536, -32768, 32768, 0, 32768, 0);
    run_sequences(120);

    repeat (3) begin
      apply_config($urandom_range(20, 400), int'($urandom_range(0, 800)) - 200,
                   $urandom_range(200, 3000), $urandom_range(1000, 30000),
                   $urandom_range(5, 80), $urandom_range(10, 200));
      run_sequences(130);
    end

    apply_config(100, 192, 1000, 15000, 20, 50);
    run_sequences(110);

    settle();
    repeat (8) @(negedge clk);

    $display("Ran %0d ticks over %0d threshold settings: %0d lifts, %0d set-downs.",
             ticks_sent, settings, lifts, set_downs);
    $display("Checked %0d results with %0d long receiver hold-offs, %0d mismatches.",
             results_seen, holds, errors);
    if (errors == 0 && tick_flags_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
